FILE: hw/rtl/wtadd_pkg.sv
// Shared types, constants and helpers for the time-of-week adder.
`default_nettype none

package wtadd_pkg;

    // command codes
    localparam logic [2:0] CMD_ADD_MS   = 3'd0;
    localparam logic [2:0] CMD_ADD_SEC  = 3'd1;
    localparam logic [2:0] CMD_ADD_MIN  = 3'd2;
    localparam logic [2:0] CMD_ADD_HOUR = 3'd3;
    localparam logic [2:0] CMD_ADD_DAY  = 3'd4;
    localparam logic [2:0] CMD_LOAD     = 3'd5;

    // digit slots, lowest digit first; hour is kept as a 24-hour digit
    localparam int NUM_DIGITS = 5;
    localparam int DIGIT_W    = 10;
    localparam int SLOT_MS    = 0;
    localparam int SLOT_SEC   = 1;
    localparam int SLOT_MIN   = 2;
    localparam int SLOT_HOUR  = 3;
    localparam int SLOT_DAY   = 4;

    localparam int unsigned RADIX_MS   = 1000;
    localparam int unsigned RADIX_SEC  = 60;
    localparam int unsigned RADIX_MIN  = 60;
    localparam int unsigned RADIX_HOUR = 24;
    localparam int unsigned RADIX_DAY  = 7;
    localparam int unsigned HALF_DAY   = 12;

    typedef logic [NUM_DIGITS-1:0][DIGIT_W-1:0] digits_t;

    // one transaction as it walks down the chain
    typedef struct packed {
        logic [2:0]  cmd;
        logic [31:0] amount;
        logic        err;
        logic [31:0] carry;
        digits_t     load_digit;
        digits_t     digit;
    } pipe_t;

    function automatic int unsigned digit_radix(input int slot);
        int unsigned r;
        r = RADIX_DAY;
        unique case (slot)
            SLOT_MS:   r = RADIX_MS;
            SLOT_SEC:  r = RADIX_SEC;
            SLOT_MIN:  r = RADIX_MIN;
            SLOT_HOUR: r = RADIX_HOUR;
            default:   r = RADIX_DAY;
        endcase
        return r;
    endfunction

    // the add command whose amount enters at a given slot
    function automatic logic [2:0] slot_cmd(input int slot);
        logic [2:0] c;
        c = CMD_ADD_DAY;
        unique case (slot)
            SLOT_MS:   c = CMD_ADD_MS;
            SLOT_SEC:  c = CMD_ADD_SEC;
            SLOT_MIN:  c = CMD_ADD_MIN;
            SLOT_HOUR: c = CMD_ADD_HOUR;
            default:   c = CMD_ADD_DAY;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/wtadd_cell.sv
// One digit cell: two-stage carry/remainder of digit plus incoming count.
`default_nettype none

module wtadd_cell
    import wtadd_pkg::*;
#(
    parameter int SLOT = 0
)
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  in_valid,
    output logic       in_ready,
    input  wire pipe_t in_data,
    output logic       out_valid,
    input  wire logic  out_ready,
    output pipe_t      out_data
);

    localparam int unsigned RADIX = digit_radix(SLOT);
    localparam logic [2:0]  UNIT  = slot_cmd(SLOT);
    localparam int          DW    = $clog2(RADIX);
    localparam int          TW    = $clog2(3 * RADIX);
    localparam int          S     = 32 + $clog2(RADIX) - 1;
    localparam logic [63:0] M64   = (64'd1 << S) / RADIX;
    localparam logic [31:0] M     = M64[31:0];
    localparam logic [31:0] R32   = 32'(RADIX);
    localparam logic [TW-1:0] R1  = TW'(RADIX);
    localparam logic [TW-1:0] R2  = TW'(2 * RADIX);

    logic          a_valid_reg;
    pipe_t         a_data_reg;
    logic [31:0]   a_cin_reg;
    logic [31:0]   a_qest_reg;
    logic          b_valid_reg;
    pipe_t         b_data_reg;
    logic [DW-1:0] digit_reg;
    logic [DW-1:0] digit_next;

    logic          b_ready;
    logic [31:0]   cin;
    logic [63:0]   prod;
    logic [63:0]   prod_sh;
    logic [31:0]   qr;
    logic [31:0]   r_est;
    logic [TW-1:0] t;
    logic [TW-1:0] r;
    logic [31:0]   q;
    pipe_t         b_data_next;

    assign b_ready  = !b_valid_reg || out_ready;
    assign in_ready = !a_valid_reg || b_ready;

    // stage A: reciprocal estimate of cin / RADIX, low by at most one
    assign cin     = (in_data.cmd == UNIT) ? in_data.amount : in_data.carry;
    assign prod    = {32'd0, cin} * {32'd0, M};
    assign prod_sh = prod >> S;

    // stage B: remainder of the estimate plus the held digit stays below 3*RADIX
    assign qr    = a_qest_reg * R32;
    assign r_est = a_cin_reg - qr;
    assign t     = r_est[TW-1:0] + TW'(digit_reg);

    always_comb
    begin
        if (t >= R2)
        begin
            r = t - R2;
            q = a_qest_reg + 32'd2;
        end
        else if (t >= R1)
        begin
            r = t - R1;
            q = a_qest_reg + 32'd1;
        end
        else
        begin
            r = t;
            q = a_qest_reg;
        end

        if (a_data_reg.cmd == CMD_LOAD && !a_data_reg.err)
            digit_next = a_data_reg.load_digit[SLOT][DW-1:0];
        else
            digit_next = r[DW-1:0];

        b_data_next             = a_data_reg;
        b_data_next.carry       = q;
        b_data_next.digit[SLOT] = DIGIT_W'(digit_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            digit_reg   <= '0;
        end
        else
        begin
            if (in_ready)
                a_valid_reg <= in_valid;
            if (b_ready)
                b_valid_reg <= a_valid_reg;
            if (a_valid_reg && b_ready)
                digit_reg <= digit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            a_data_reg <= in_data;
            a_cin_reg  <= cin;
            a_qest_reg <= prod_sh[31:0];
        end
        if (a_valid_reg && b_ready)
            b_data_reg <= b_data_next;
    end

    assign out_valid = b_valid_reg;
    assign out_data  = b_data_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/week_time_adder_top.sv
// Top level of the time-of-week adder: entry checks, digit cell chain, result packing.
//
//  channel  | dir | handshake                      | payload
//  ---------+-----+--------------------------------+---------------------------------------
//  s_axis   | in  | s_axis_tvalid / s_axis_tready  | tuser: command; tdata: amount, load_*
//  m_axis   | out | m_axis_tvalid / m_axis_tready  | tdata: timestamp; tuser: load_error
//
// One transaction enters per cycle while s_axis_tready is high; its result passes through
// ten register stages, two per digit cell (reciprocal multiply, then remainder correction
// and digit update).
// Each cell owns its digit, so transactions follow each other without waiting.
// Reset clears the time to weekday 0, 00:00:00.000 AM and empties the chain.
// A stalled output backs up stage by stage; input stalls only once every stage is full.
`default_nettype none

module week_time_adder_top
    import wtadd_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // amount[31:0], load_weekday[34:32], load_hour[38:35], load_minute[44:39],
    // load_pm[45], load_second[51:46], load_millisecond[61:52], zero pad
    input  wire logic [63:0] s_axis_tdata,
    // command[2:0]
    input  wire logic [2:0]  s_axis_tuser,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // weekday[2:0], hour[6:3], minute[12:7], pm[13], second[19:14],
    // millisecond[29:20], zero pad
    output logic [31:0]      m_axis_tdata,
    // load_error[0]
    output logic [0:0]       m_axis_tuser
);

    localparam int HW = $clog2(RADIX_HOUR);

    logic [2:0]  load_weekday;
    logic [3:0]  load_hour;
    logic [5:0]  load_minute;
    logic        load_pm;
    logic [5:0]  load_second;
    logic [9:0]  load_millisecond;
    logic [HW-1:0] load_h24;
    logic        bad_load;
    pipe_t       entry;

    logic  link_valid [NUM_DIGITS+1];
    logic  link_ready [NUM_DIGITS+1];
    pipe_t link_data  [NUM_DIGITS+1];

    logic [HW-1:0] h24;
    logic          pm;
    logic [3:0]    hour;
    pipe_t         res;

    assign load_weekday     = s_axis_tdata[34:32];
    assign load_hour        = s_axis_tdata[38:35];
    assign load_minute      = s_axis_tdata[44:39];
    assign load_pm          = s_axis_tdata[45];
    assign load_second      = s_axis_tdata[51:46];
    assign load_millisecond = s_axis_tdata[61:52];

    assign bad_load = (load_weekday >= 3'(RADIX_DAY)) || (load_hour >= 4'(HALF_DAY)) ||
                      (load_minute >= 6'(RADIX_MIN)) || (load_second >= 6'(RADIX_SEC)) ||
                      (load_millisecond >= 10'(RADIX_MS));

    // only used when the load is in range, so hour < 12 here
    assign load_h24 = HW'(load_hour) + (load_pm ? HW'(HALF_DAY) : HW'(0));

    always_comb
    begin
        entry                       = '0;
        entry.cmd                   = s_axis_tuser;
        entry.amount                = s_axis_tdata[31:0];
        entry.err                   = (s_axis_tuser == CMD_LOAD) && bad_load;
        entry.load_digit[SLOT_MS]   = DIGIT_W'(load_millisecond);
        entry.load_digit[SLOT_SEC]  = DIGIT_W'(load_second);
        entry.load_digit[SLOT_MIN]  = DIGIT_W'(load_minute);
        entry.load_digit[SLOT_HOUR] = DIGIT_W'(load_h24);
        entry.load_digit[SLOT_DAY]  = DIGIT_W'(load_weekday);
    end

    assign link_valid[0] = s_axis_tvalid;
    assign link_data[0]  = entry;
    assign s_axis_tready = link_ready[0];

    for (genvar i = 0; i < NUM_DIGITS; i++)
    begin : g_cell
        wtadd_cell #(
            .SLOT (i)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (link_valid[i]),
            .in_ready  (link_ready[i]),
            .in_data   (link_data[i]),
            .out_valid (link_valid[i+1]),
            .out_ready (link_ready[i+1]),
            .out_data  (link_data[i+1])
        );
    end

    assign link_ready[NUM_DIGITS] = m_axis_tready;
    assign m_axis_tvalid          = link_valid[NUM_DIGITS];
    assign res                    = link_data[NUM_DIGITS];

    // split the 24-hour digit back into 12-hour hour and PM flag
    assign h24  = res.digit[SLOT_HOUR][HW-1:0];
    assign pm   = (h24 >= HW'(HALF_DAY));
    assign hour = pm ? 4'(h24 - HW'(HALF_DAY)) : 4'(h24);

    assign m_axis_tdata = {2'b00,
                           res.digit[SLOT_MS][9:0],
                           res.digit[SLOT_SEC][5:0],
                           pm,
                           res.digit[SLOT_MIN][5:0],
                           hour,
                           res.digit[SLOT_DAY][2:0]};
    assign m_axis_tuser = res.err;

endmodule

`default_nettype wire

FILE: tb/week_time_adder_checker.sv
// Checker for the time-of-week adder: predicts each timestamp and compares the result stream.
module week_time_adder_checker
    import wtadd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,
    input  logic [2:0]  s_axis_tuser,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [31:0] m_axis_tdata,
    input  logic [0:0]  m_axis_tuser,
    output int          mismatches,
    output int          pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [2:0] wday;
        logic [3:0] hour;
        logic [5:0] minute;
        logic       pm;
        logic [5:0] second;
        logic [9:0] msec;
    } tow_t;

    typedef struct packed {
        tow_t tow;
        logic err;
    } stamp_t;

    tow_t   clock_now;
    stamp_t stamp_q[$];
    stamp_t want;

    function automatic tow_t carry_days(tow_t t, longint unsigned n);
        t.wday = 3'((longint'(t.wday) + n % 7) % 7);
        return t;
    endfunction

    // each pass of twelve hours flips the PM flag; PM back to AM starts a new day
    function automatic tow_t carry_hours(tow_t t, longint unsigned n);
        longint unsigned h, halves, flip, days;
        h      = longint'(t.hour) + n;
        halves = h / 12;
        flip   = halves & 1;
        days   = (halves >> 1) + ((longint'(t.pm) + flip) >> 1);
        t.hour = 4'(h % 12);
        t.pm   = t.pm ^ flip[0];
        return carry_days(t, days);
    endfunction

    function automatic tow_t carry_minutes(tow_t t, longint unsigned n);
        longint unsigned m;
        m        = longint'(t.minute) + n;
        t.minute = 6'(m % 60);
        return carry_hours(t, m / 60);
    endfunction

    function automatic tow_t carry_seconds(tow_t t, longint unsigned n);
        longint unsigned s;
        s        = longint'(t.second) + n;
        t.second = 6'(s % 60);
        return carry_minutes(t, s / 60);
    endfunction

    function automatic tow_t carry_msecs(tow_t t, longint unsigned n);
        longint unsigned ms;
        ms     = longint'(t.msec) + n;
        t.msec = 10'(ms % 1000);
        return carry_seconds(t, ms / 1000);
    endfunction

    function automatic stamp_t next_stamp(tow_t t, logic [2:0] cmd, logic [63:0] d);
        stamp_t          r;
        longint unsigned amount;
        amount = longint'(d[31:0]);
        r.err  = 1'b0;
        case (cmd)
            CMD_ADD_MS:   t = carry_msecs(t, amount);
            CMD_ADD_SEC:  t = carry_seconds(t, amount);
            CMD_ADD_MIN:  t = carry_minutes(t, amount);
            CMD_ADD_HOUR: t = carry_hours(t, amount);
            CMD_ADD_DAY:  t = carry_days(t, amount);
            CMD_LOAD:
            begin
                if (d[34:32] >= 7 || d[38:35] >= 12 || d[44:39] >= 60 ||
                    d[51:46] >= 60 || d[61:52] >= 1000)
                    r.err = 1'b1;
                else
                begin
                    t.wday   = d[34:32];
                    t.hour   = d[38:35];
                    t.minute = d[44:39];
                    t.pm     = d[45];
                    t.second = d[51:46];
                    t.msec   = d[61:52];
                end
            end
            default: ;
        endcase
        r.tow = t;
        return r;
    endfunction

    task automatic flag_mismatch(input string what, input longint got, input longint exp_val);
        mismatches++;
        $display("%0t: %s mismatch: got %0d, want %0d", $realtime, what, got, exp_val);
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            clock_now = '0;
            stamp_q.delete();
        end
        else
        begin
            // result side first: a result at this edge belongs to an older transaction
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (stamp_q.size() == 0)
                    flag_mismatch("unexpected result", longint'(m_axis_tdata), 0);
                else
                begin
                    want = stamp_q.pop_front();
                    if (m_axis_tdata[2:0] != want.tow.wday)
                        flag_mismatch("weekday", m_axis_tdata[2:0], want.tow.wday);
                    if (m_axis_tdata[6:3] != want.tow.hour)
                        flag_mismatch("hour", m_axis_tdata[6:3], want.tow.hour);
                    if (m_axis_tdata[12:7] != want.tow.minute)
                        flag_mismatch("minute", m_axis_tdata[12:7], want.tow.minute);
                    if (m_axis_tdata[13] != want.tow.pm)
                        flag_mismatch("pm", m_axis_tdata[13], want.tow.pm);
                    if (m_axis_tdata[19:14] != want.tow.second)
                        flag_mismatch("second", m_axis_tdata[19:14], want.tow.second);
                    if (m_axis_tdata[29:20] != want.tow.msec)
                        flag_mismatch("millisecond", m_axis_tdata[29:20], want.tow.msec);
                    if (m_axis_tdata[31:30] != 2'b00)
                        flag_mismatch("tdata pad", m_axis_tdata[31:30], 0);
                    if (m_axis_tuser[0] != want.err)
                        flag_mismatch("load_error", m_axis_tuser[0], want.err);
                end
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                want      = next_stamp(clock_now, s_axis_tuser, s_axis_tdata);
                clock_now = want.tow;
                stamp_q.push_back(want);
            end
        end
        pending <= stamp_q.size();
    end

endmodule

FILE: tb/week_time_adder_top_test.sv
// Testbench top for the time-of-week adder: clock, reset, stimulus and verdict.
module week_time_adder_top_test
    import wtadd_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          RANDOM_ITEMS = 1750;
    localparam int          CYCLE_LIMIT  = 300000;
    localparam int          DRAIN_CYCLES = 25;
    localparam logic [31:0] ALL_ONES     = 32'hFFFF_FFFF;
    // codes the block does not decode
    localparam logic [2:0]  CMD_SPARE_6  = 3'd6;
    localparam logic [2:0]  CMD_SPARE_7  = 3'd7;
    localparam logic [2:0]  ADD_CODES [5] =
        '{CMD_ADD_MS, CMD_ADD_SEC, CMD_ADD_MIN, CMD_ADD_HOUR, CMD_ADD_DAY};

    typedef struct packed {
        logic [2:0]  cmd;
        logic [31:0] amount;
        logic [2:0]  lw;
        logic [3:0]  lh;
        logic [5:0]  lm;
        logic        lp;
        logic [5:0]  ls;
        logic [9:0]  lms;
    } txn_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata = '0;
    logic [2:0]  s_axis_tuser = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;
    logic [0:0]  m_axis_tuser;

    int mismatches;
    int pending;
    int cycles = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;

    week_time_adder_top u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    week_time_adder_checker u_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .mismatches    (mismatches),
        .pending       (pending)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("week_time_adder_top test failed");
            $finish;
        end
    end

    always @(posedge clk)
        m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);

    function automatic txn_t make_txn(logic [2:0] cmd, logic [31:0] amount,
                                      logic [2:0] lw, logic [3:0] lh, logic [5:0] lm,
                                      logic lp, logic [5:0] ls, logic [9:0] lms);
        txn_t t;
        t = '{cmd, amount, lw, lh, lm, lp, ls, lms};
        return t;
    endfunction

    function automatic txn_t random_txn();
        txn_t t;
        int   sel;
        sel = $urandom_range(99);
        // unused load fields still toggle on adds
        t = make_txn(CMD_LOAD, $urandom(), 3'($urandom_range(7)), 4'($urandom_range(15)),
                     6'($urandom_range(63)), 1'($urandom_range(1)),
                     6'($urandom_range(63)), 10'($urandom_range(1023)));
        if (sel < 70)
        begin
            t.cmd = ADD_CODES[$urandom_range(4)];
            case ($urandom_range(3))
                0: t.amount = $urandom_range(3);
                1: t.amount = $urandom_range(5000);
                2: t.amount = $urandom();
                default: t.amount = $urandom_range(1) ? ALL_ONES : '0;
            endcase
        end
        else if (sel < 94)
        begin
            // mostly well-formed timestamps, some with a digit out of range
            if ($urandom_range(4) != 0)
            begin
                t.lw  = 3'($urandom_range(6));
                t.lh  = 4'($urandom_range(11));
                t.lm  = 6'($urandom_range(59));
                t.ls  = 6'($urandom_range(59));
                t.lms = 10'($urandom_range(999));
            end
        end
        else
            t.cmd = $urandom_range(1) ? CMD_SPARE_6 : CMD_SPARE_7;
        return t;
    endfunction

    task automatic send_txn(input txn_t t);
        if ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= t.cmd;
        s_axis_tdata  <= {2'b00, t.lms, t.ls, t.lp, t.lm, t.lh, t.lw, t.amount};
        do @(posedge clk); while (!s_axis_tready);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        do @(posedge clk); while (pending != 0);
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct = 17;
        recv_idle_pct = 79;

        send_txn(make_txn(CMD_ADD_MS,   '0,       '0, '0, '0, 1'b0, '0, '0));
        send_txn(make_txn(CMD_ADD_MS,   ALL_ONES, '0, '0, '0, 1'b0, '0, '0));
        send_txn(make_txn(CMD_ADD_SEC,  ALL_ONES, '0, '0, '0, 1'b0, '0, '0));
        send_txn(make_txn(CMD_ADD_MIN,  ALL_ONES, '0, '0, '0, 1'b0, '0, '0));
        send_txn(make_txn(CMD_ADD_HOUR, ALL_ONES, '0, '0, '0, 1'b0, '0, '0));
        send_txn(make_txn(CMD_ADD_DAY,  ALL_ONES, '0, '0, '0, 1'b0, '0, '0));
        // last millisecond of the week, then roll over
        send_txn(make_txn(CMD_LOAD,     '0,       6, 11, 59, 1'b1, 59, 999));
        send_txn(make_txn(CMD_ADD_MS,   1,        '0, '0, '0, 1'b0, '0, '0));
        send_txn(make_txn(CMD_LOAD,     '0,       7, 3, 4, 1'b1, 5, 6));
        send_txn(make_txn(CMD_LOAD,     '0,       2, 12, 4, 1'b0, 5, 6));
        send_txn(make_txn(CMD_LOAD,     '0,       2, 3, 60, 1'b1, 5, 6));
        send_txn(make_txn(CMD_LOAD,     '0,       2, 3, 4, 1'b0, 60, 6));
        send_txn(make_txn(CMD_LOAD,     '0,       2, 3, 4, 1'b1, 5, 1000));
        send_txn(make_txn(CMD_LOAD,     ALL_ONES, 7, 15, 63, 1'b1, 63, 1023));
        send_txn(make_txn(CMD_LOAD,     '0,       '0, '0, '0, 1'b0, '0, '0));
        send_txn(make_txn(CMD_SPARE_6,  ALL_ONES, 7, 15, 63, 1'b1, 63, 1023));
        send_txn(make_txn(CMD_SPARE_7,  12345,    1, 2, 3, 1'b0, 4, 5));
        send_txn(make_txn(CMD_ADD_HOUR, 12,       '0, '0, '0, 1'b0, '0, '0));
        send_txn(make_txn(CMD_ADD_HOUR, 12,       '0, '0, '0, 1'b0, '0, '0));
        send_txn(make_txn(CMD_ADD_DAY,  7,        '0, '0, '0, 1'b0, '0, '0));
        send_txn(make_txn(CMD_ADD_MIN,  60,       '0, '0, '0, 1'b0, '0, '0));
        send_txn(make_txn(CMD_ADD_SEC,  60,       '0, '0, '0, 1'b0, '0, '0));
        send_txn(make_txn(CMD_ADD_MS,   1000,     '0, '0, '0, 1'b0, '0, '0));

        // hold off until the pipeline has emptied
        drain();

        for (int phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0:
                begin
                    send_idle_pct = 17;
                    recv_idle_pct = 79;
                end
                1:
                begin
                    send_idle_pct = 79;
                    recv_idle_pct = 17;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            for (int i = 0; i < RANDOM_ITEMS / 3; i++)
                send_txn(random_txn());
        end

        drain();
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0 && pending == 0)
            $display("week_time_adder_top test passed");
        else
            $display("week_time_adder_top test failed");
        $finish;
    end

endmodule
